// ===== design/rbs_pkg.sv =====
package rbs_pkg;

  // Field widths
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned BACKOFF_W = 20;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned OUTAGE_W  = 32;
  localparam int unsigned ADDR_W    = 5;

  // Event codes
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UP      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OUTCOME = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd4;

  // Register indexes (word address paddr[4:2])
  localparam logic [2:0] REG_BACKOFF_MIN  = 3'd0;
  localparam logic [2:0] REG_BACKOFF_MAX  = 3'd1;
  localparam logic [2:0] REG_CONN_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_RST_THRESH   = 3'd3;
  localparam logic [2:0] REG_RST_COOLDOWN = 3'd4;
  localparam logic [2:0] REG_RST_RETRYMIN = 3'd5;

  // Encoded link phase as seen on the result channel
  localparam logic [PHASE_W-1:0] LP_CONNECTING = 3'd0;
  localparam logic [PHASE_W-1:0] LP_CONNECTED  = 3'd1;
  localparam logic [PHASE_W-1:0] LP_WAIT       = 3'd2;
  localparam logic [PHASE_W-1:0] LP_PENDING    = 3'd3;
  localparam logic [PHASE_W-1:0] LP_STOPPED    = 3'd4;

  typedef enum logic [4:0] {
    PH_CONNECTING = 5'b00001,
    PH_CONNECTED  = 5'b00010,
    PH_WAIT       = 5'b00100,
    PH_PENDING    = 5'b01000,
    PH_STOPPED    = 5'b10000
  } phase_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_CONNECTING: code = LP_CONNECTING;
      PH_CONNECTED:  code = LP_CONNECTED;
      PH_WAIT:       code = LP_WAIT;
      PH_PENDING:    code = LP_PENDING;
      PH_STOPPED:    code = LP_STOPPED;
      default:       code = LP_CONNECTING;
    endcase
    return code;
  endfunction

endpackage

// ===== design/rbs_ifs.sv =====
// Event channel: one link event per beat
interface rbs_evt_if;
  logic                        valid;
  logic                        ready;
  logic [rbs_pkg::MODE_W-1:0]  mode;
  logic                        reset_good;

  modport source (output valid, output mode, output reset_good, input ready);
  modport sink   (input valid, input mode, input reset_good, output ready);
endinterface

// Status channel: one result per event beat
interface rbs_sts_if;
  logic                          valid;
  logic                          ready;
  logic [rbs_pkg::PHASE_W-1:0]   link_phase;
  logic                          connect_request;
  logic                          reset_request;
  logic [rbs_pkg::BACKOFF_W-1:0] backoff_now_ms;
  logic [rbs_pkg::OUTAGE_W-1:0]  outage_now_ms;

  modport source (output valid, output link_phase, output connect_request,
                  output reset_request, output backoff_now_ms, output outage_now_ms,
                  input ready);
  modport sink   (input valid, input link_phase, input connect_request,
                  input reset_request, input backoff_now_ms, input outage_now_ms,
                  output ready);
endinterface

// ===== design/reconnect_backoff_supervisor.sv =====
// channel   dir   handshake      payload
// evt       in    valid/ready    mode[2:0], reset_good
// sts       out   valid/ready    link_phase, connect_request, reset_request,
//                                backoff_now_ms[19:0], outage_now_ms[31:0]
// apb       in    psel/penable   6 regs at paddr 4*i (0,1: 20-bit), pready tied high
//
// One event per clock; its status beat is registered and shows in the next cycle.
// The rate is set by the single state update between the state registers and
// the status register. A new event is taken whenever the status register is
// empty or being drained this cycle. Reset (rst, synchronous) restores the
// register defaults, phase connecting and clears all timers.
module reconnect_backoff_supervisor #(
  parameter int unsigned TIMER_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  rbs_evt_if.sink                      evt,
  rbs_sts_if.source                    sts,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbs_pkg::ADDR_W-1:0]   paddr,
  input  logic [rbs_pkg::CFG_W-1:0]    pwdata,
  output logic [rbs_pkg::CFG_W-1:0]    prdata,
  output logic                         pready
);

  localparam int unsigned CW = (TIMER_BITS > 32) ? TIMER_BITS : 32;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  // Configuration registers
  logic [rbs_pkg::BACKOFF_W-1:0] backoff_min;
  logic [rbs_pkg::BACKOFF_W-1:0] backoff_max;
  logic [rbs_pkg::CFG_W-1:0]     conn_timeout;
  logic [rbs_pkg::CFG_W-1:0]     rst_thresh;
  logic [rbs_pkg::CFG_W-1:0]     rst_cooldown;
  logic [rbs_pkg::CFG_W-1:0]     rst_retrymin;
  // cooldown credit after a failed reset, kept in step with the registers
  logic [rbs_pkg::CFG_W-1:0]     cool_delta;

  // Supervisor state
  rbs_pkg::phase_t               phase, phase_next;
  logic [rbs_pkg::BACKOFF_W-1:0] backoff, backoff_next;
  logic [rbs_pkg::BACKOFF_W-1:0] wait_left, wait_left_next;
  logic [TIMER_BITS-1:0]         attempt, attempt_next;
  logic [TIMER_BITS-1:0]         outage, outage_next;
  logic                          outage_run, outage_run_next;
  logic [TIMER_BITS-1:0]         since_reset, since_reset_next;
  logic                          reset_seen, reset_seen_next;

  logic                          conn_pulse;
  logic                          rst_pulse;
  logic                          drop;
  logic                          accept;
  logic                          cfg_wr;
  logic [rbs_pkg::BACKOFF_W:0]   doubled;
  logic [CW:0]                   since_sum;
  logic [CW-1:0]                 outage_ext;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == TMAX) ? v : v + 1'b1;
  endfunction

  // shortened = max(ceil(c/4), retry); credit = c - shortened when positive
  function automatic logic [rbs_pkg::CFG_W-1:0] credit_of(
    input logic [rbs_pkg::CFG_W-1:0] c,
    input logic [rbs_pkg::CFG_W-1:0] retry
  );
    logic [rbs_pkg::CFG_W-1:0] quarter;
    logic [rbs_pkg::CFG_W-1:0] shortened;
    quarter   = (c >> 2) + {31'd0, |c[1:0]};
    shortened = (quarter < retry) ? retry : quarter;
    return (c > shortened) ? c - shortened : '0;
  endfunction

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_min  <= 20'd1000;
      backoff_max  <= 20'd30000;
      conn_timeout <= 32'd20000;
      rst_thresh   <= 32'd120000;
      rst_cooldown <= 32'd600000;
      rst_retrymin <= 32'd60000;
      cool_delta   <= 32'd450000;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        rbs_pkg::REG_BACKOFF_MIN:  backoff_min  <= pwdata[rbs_pkg::BACKOFF_W-1:0];
        rbs_pkg::REG_BACKOFF_MAX:  backoff_max  <= pwdata[rbs_pkg::BACKOFF_W-1:0];
        rbs_pkg::REG_CONN_TIMEOUT: conn_timeout <= pwdata;
        rbs_pkg::REG_RST_THRESH:   rst_thresh   <= pwdata;
        rbs_pkg::REG_RST_COOLDOWN: begin
          rst_cooldown <= pwdata;
          cool_delta   <= credit_of(pwdata, rst_retrymin);
        end
        rbs_pkg::REG_RST_RETRYMIN: begin
          rst_retrymin <= pwdata;
          cool_delta   <= credit_of(rst_cooldown, pwdata);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rbs_pkg::REG_BACKOFF_MIN:  prdata = {12'd0, backoff_min};
      rbs_pkg::REG_BACKOFF_MAX:  prdata = {12'd0, backoff_max};
      rbs_pkg::REG_CONN_TIMEOUT: prdata = conn_timeout;
      rbs_pkg::REG_RST_THRESH:   prdata = rst_thresh;
      rbs_pkg::REG_RST_COOLDOWN: prdata = rst_cooldown;
      rbs_pkg::REG_RST_RETRYMIN: prdata = rst_retrymin;
      default:                   prdata = '0;
    endcase
  end

  // Handshake: the status register parts the two sides
  assign evt.ready = !sts.valid || sts.ready;
  assign accept    = evt.valid && evt.ready;

  assign doubled   = {backoff, 1'b0};
  assign since_sum = {1'b0, CW'(since_reset)} + {1'b0, CW'(cool_delta)};

  // Next state for one event
  always_comb begin
    phase_next       = phase;
    backoff_next     = backoff;
    wait_left_next   = wait_left;
    attempt_next     = attempt;
    outage_next      = outage;
    outage_run_next  = outage_run;
    since_reset_next = since_reset;
    reset_seen_next  = reset_seen;
    conn_pulse       = 1'b0;
    rst_pulse        = 1'b0;
    drop             = 1'b0;

    if (phase != rbs_pkg::PH_STOPPED) begin
      case (evt.mode)
        rbs_pkg::MODE_TICK: begin
          if (outage_run) outage_next = sat_inc(outage);
          if (reset_seen) since_reset_next = sat_inc(since_reset);
          if (phase == rbs_pkg::PH_CONNECTING) begin
            attempt_next = sat_inc(attempt);
            drop = CW'(attempt_next) > CW'(conn_timeout);
          end else if (phase == rbs_pkg::PH_WAIT) begin
            if (wait_left <= 20'd1) begin
              wait_left_next = '0;
              phase_next     = rbs_pkg::PH_CONNECTING;
              attempt_next   = '0;
              conn_pulse     = 1'b1;
              backoff_next   = (doubled > {1'b0, backoff_max}) ? backoff_max
                                                               : doubled[19:0];
            end else begin
              wait_left_next = wait_left - 1'b1;
            end
          end
        end
        rbs_pkg::MODE_UP: begin
          if (phase == rbs_pkg::PH_CONNECTING || phase == rbs_pkg::PH_CONNECTED) begin
            phase_next      = rbs_pkg::PH_CONNECTED;
            backoff_next    = backoff_min;
            outage_run_next = 1'b0;
            outage_next     = '0;
          end
        end
        rbs_pkg::MODE_DOWN: begin
          drop = (phase == rbs_pkg::PH_CONNECTING || phase == rbs_pkg::PH_CONNECTED);
        end
        rbs_pkg::MODE_OUTCOME: begin
          if (phase == rbs_pkg::PH_PENDING) begin
            if (evt.reset_good) begin
              outage_run_next = 1'b0;
              outage_next     = '0;
            end else begin
              since_reset_next = (since_sum >= {1'b0, CW'(TMAX)}) ? TMAX
                                 : since_sum[TIMER_BITS-1:0];
            end
            phase_next     = rbs_pkg::PH_WAIT;
            wait_left_next = backoff;
          end
        end
        rbs_pkg::MODE_STOP: phase_next = rbs_pkg::PH_STOPPED;
        default: ;
      endcase
    end

    // Link went down: start the outage and decide between reset and backoff
    if (drop) begin
      if (!outage_run_next) begin
        outage_run_next = 1'b1;
        outage_next     = '0;
      end
      if ((CW'(outage_next) >= CW'(rst_thresh)) &&
          (!reset_seen_next || (CW'(since_reset_next) >= CW'(rst_cooldown)))) begin
        phase_next       = rbs_pkg::PH_PENDING;
        reset_seen_next  = 1'b1;
        since_reset_next = '0;
        rst_pulse        = 1'b1;
      end else begin
        phase_next     = rbs_pkg::PH_WAIT;
        wait_left_next = backoff_next;
      end
    end
  end

  assign outage_ext = CW'(outage_next);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rbs_pkg::PH_CONNECTING;
      backoff     <= 20'd1000;
      wait_left   <= '0;
      attempt     <= '0;
      outage      <= '0;
      outage_run  <= 1'b0;
      since_reset <= '0;
      reset_seen  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      backoff     <= backoff_next;
      wait_left   <= wait_left_next;
      attempt     <= attempt_next;
      outage      <= outage_next;
      outage_run  <= outage_run_next;
      since_reset <= since_reset_next;
      reset_seen  <= reset_seen_next;
    end
  end

  // Status register
  always_ff @(posedge clk) begin
    if (rst) begin
      sts.valid <= 1'b0;
    end else if (accept) begin
      sts.valid <= 1'b1;
    end else if (sts.ready) begin
      sts.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sts.link_phase      <= rbs_pkg::phase_code(phase_next);
      sts.connect_request <= conn_pulse;
      sts.reset_request   <= rst_pulse;
      sts.backoff_now_ms  <= backoff_next;
      if (!outage_run_next) begin
        sts.outage_now_ms <= '0;
      end else if (outage_ext > CW'(32'hFFFF_FFFF)) begin
        sts.outage_now_ms <= '1;
      end else begin
        sts.outage_now_ms <= outage_ext[31:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    sts.valid |-> !(sts.connect_request && sts.reset_request))
    else $error("connect and reset requested in one beat");

  a_rst_pending: assert property (@(posedge clk) disable iff (rst)
    (sts.valid && sts.reset_request) |-> (sts.link_phase == rbs_pkg::LP_PENDING))
    else $error("reset request without reset pending phase");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == rbs_pkg::PH_STOPPED) |=> (phase == rbs_pkg::PH_STOPPED))
    else $error("left stopped phase without reset");

  a_outage_idle: assert property (@(posedge clk) disable iff (rst)
    !outage_run |-> (outage == '0))
    else $error("outage timer nonzero while no outage");

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> sts.valid)
    else $error("accepted event produced no status beat");
`endif

endmodule
